// ===== sv/ctl_pkg.sv =====
`timescale 1ns / 1ps
// token lexer package: token codes, record types, classification tables
// no dependencies
package ctl_pkg;

  localparam int KEYWORD_MAX_LEN_DEF = 8;
  localparam int KW_COUNT = 28;
  localparam int KW_BYTES = 8;
  localparam int FIFO_DEPTH = 4;

  localparam logic [6:0] K_IDENT   = 7'd28;
  localparam logic [6:0] K_NUMBER  = 7'd29;
  localparam logic [6:0] K_STRING  = 7'd30;
  localparam logic [6:0] K_PAIR0   = 7'd31;
  localparam logic [6:0] K_SINGLE0 = 7'd48;
  localparam logic [6:0] K_UNKNOWN = 7'd71;
  localparam logic [6:0] K_EOF     = 7'd72;

  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  function automatic logic [63:0] kw_text(input int idx);
    logic [63:0] s;
    case (idx)
      0: s = 64'("void");     1: s = 64'("volatile"); 2: s = 64'("char");
      3: s = 64'("const");    4: s = 64'("continue"); 5: s = 64'("case");
      6: s = 64'("short");    7: s = 64'("signed");   8: s = 64'("static");
      9: s = 64'("struct");   10: s = 64'("switch");  11: s = 64'("sizeof");
      12: s = 64'("int");     13: s = 64'("long");    14: s = 64'("float");
      15: s = 64'("for");     16: s = 64'("double");  17: s = 64'("do");
      18: s = 64'("default"); 19: s = 64'("else");    20: s = 64'("enum");
      21: s = 64'("extern");  22: s = 64'("return");  23: s = 64'("while");
      24: s = 64'("unsigned"); 25: s = 64'("union");  26: s = 64'("typedef");
      27: s = 64'("goto");
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input int idx);
    logic [63:0] s;
    logic [3:0]  n;
    s = kw_text(idx);
    n = 4'd0;
    for (int i = 0; i < KW_BYTES; i++) begin
      if (s[8*i +: 8] != 8'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic is_pair_start(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "=" ||
           c == "!" || c == "<" || c == ">" || c == "&" || c == "|" || c == "#";
  endfunction

  // returns {hit, kind}
  function automatic logic [7:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [4:0] i;
    logic       hit;
    hit = 1'b1;
    i = 5'd0;
    if (p == "+" && c == "+") i = 5'd0;
    else if (p == "-" && c == "-") i = 5'd1;
    else if (p == "+" && c == "=") i = 5'd2;
    else if (p == "-" && c == "=") i = 5'd3;
    else if (p == "*" && c == "=") i = 5'd4;
    else if (p == "/" && c == "=") i = 5'd5;
    else if (p == "%" && c == "=") i = 5'd6;
    else if (p == "=" && c == "=") i = 5'd7;
    else if (p == "!" && c == "=") i = 5'd8;
    else if (p == "<" && c == "=") i = 5'd9;
    else if (p == ">" && c == "=") i = 5'd10;
    else if (p == "&" && c == "&") i = 5'd11;
    else if (p == "|" && c == "|") i = 5'd12;
    else if (p == "<" && c == "<") i = 5'd13;
    else if (p == ">" && c == ">") i = 5'd14;
    else if (p == "#" && c == "#") i = 5'd15;
    else if (p == "-" && c == ">") i = 5'd16;
    else hit = 1'b0;
    return {hit, K_PAIR0 + 7'(i)};
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      "+": k = K_SINGLE0 + 7'd0;   "-": k = K_SINGLE0 + 7'd1;
      "*": k = K_SINGLE0 + 7'd2;   "/": k = K_SINGLE0 + 7'd3;
      "%": k = K_SINGLE0 + 7'd4;   "=": k = K_SINGLE0 + 7'd5;
      "&": k = K_SINGLE0 + 7'd6;   "|": k = K_SINGLE0 + 7'd7;
      "^": k = K_SINGLE0 + 7'd8;   "~": k = K_SINGLE0 + 7'd9;
      "!": k = K_SINGLE0 + 7'd10;  "(": k = K_SINGLE0 + 7'd11;
      ")": k = K_SINGLE0 + 7'd12;  "{": k = K_SINGLE0 + 7'd13;
      "}": k = K_SINGLE0 + 7'd14;  "[": k = K_SINGLE0 + 7'd15;
      "]": k = K_SINGLE0 + 7'd16;  ";": k = K_SINGLE0 + 7'd17;
      ":": k = K_SINGLE0 + 7'd18;  ",": k = K_SINGLE0 + 7'd19;
      ".": k = K_SINGLE0 + 7'd20;  "?": k = K_SINGLE0 + 7'd21;
      "#": k = K_SINGLE0 + 7'd22;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/ctl_if.sv =====
`timescale 1ns / 1ps
// byte input and token output channel interfaces
// no dependencies
interface ctl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_input;
  modport source (output valid, byte_req, end_of_input, input ready);
  modport sink   (input valid, byte_req, end_of_input, output ready);
endinterface

interface ctl_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic        last;
  modport source (output valid, token_kind, token_start, token_length, last, input ready);
  modport sink   (input valid, token_kind, token_start, token_length, last, output ready);
endinterface

// ===== sv/c_token_lexer_unit.sv =====
`timescale 1ns / 1ps
// top level of the streaming C lexer
// depends on ctl_pkg, ctl_if, ctl_front, ctl_back
//
// Takes one source byte per cycle and emits token records (kind, start offset,
// saturating length, last mark). A byte that ends one token and is itself a
// one-byte token, and an end-of-input marker that flushes a pending token, each
// push two records, and input pauses while the four-entry token queue has fewer
// than two free slots, so sustained rate is one byte per cycle while output keeps
// up. Tokens pass through the queue and then the output register after the byte
// that completes them.
module c_token_lexer_unit #(
  parameter int KEYWORD_MAX_LEN = ctl_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ctl_in_if.sink    in_if,
  ctl_out_if.source out_if
);

  ctl_pkg::push_t push;
  logic           room_ok;

  ctl_front #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .room_ok(room_ok), .push(push)
  );

  ctl_back u_back (
    .clk(clk), .rst_n(rst_n), .push(push), .room_ok(room_ok), .out_if(out_if)
  );

endmodule

// ===== sv/ctl_front.sv =====
`timescale 1ns / 1ps
// lexer front: scans one byte per cycle while the back has room and produces up to two token records
// depends on ctl_pkg, ctl_if
module ctl_front #(
  parameter int KEYWORD_MAX_LEN = ctl_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ctl_in_if.sink         in_if,
  input  logic           room_ok,
  output ctl_pkg::push_t push
);

  localparam int IW = $clog2(KEYWORD_MAX_LEN);

  typedef enum logic [7:0] {
    M_IDLE   = 8'b0000_0001,
    M_LINE   = 8'b0000_0010,
    M_BLOCK  = 8'b0000_0100,
    M_STAR   = 8'b0000_1000,
    M_STRING = 8'b0001_0000,
    M_IDENT  = 8'b0010_0000,
    M_NUMBER = 8'b0100_0000,
    M_OP     = 8'b1000_0000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        long_r, long_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [7:0]  wbuf_r [KEYWORD_MAX_LEN];

  logic        acc, eoi, do_start, wr_en;
  logic [IW-1:0] wr_idx;
  logic [7:0]  c;
  logic [6:0]  wkind;
  logic [7:0]  pk;
  logic [63:0] rj;
  logic [15:0] len_inc;
  ctl_pkg::tok_t em [2];
  logic [1:0]  n;

  assign in_if.ready = room_ok;
  assign acc = in_if.valid && room_ok;
  assign c = in_if.byte_req;
  assign eoi = in_if.end_of_input || c == 8'd0;
  assign len_inc = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
  assign pk = ctl_pkg::pair_kind(pend_r, c);

  // keyword lookup over the stored prefix, right-justified like the table
  always_comb begin
    rj = '0;
    for (int i = 0; i < ctl_pkg::KW_BYTES; i++) begin
      if (16'(i) < len_r) rj = {rj[55:0], wbuf_r[i]};
    end
    wkind = ctl_pkg::K_IDENT;
    if (!long_r && len_r <= 16'(ctl_pkg::KW_BYTES)) begin
      for (int k = ctl_pkg::KW_COUNT - 1; k >= 0; k--) begin
        if (len_r == 16'(ctl_pkg::kw_len(k)) && rj == ctl_pkg::kw_text(k)) wkind = 7'(k);
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r; pend_nxt = pend_r; prev_nxt = prev_r; long_nxt = long_r;
    len_nxt = len_r; start_nxt = start_r; pos_nxt = pos_r;
    wr_en = 1'b0; wr_idx = '0; do_start = 1'b0;
    n = 2'd0;
    em[0] = '0; em[1] = '0;
    if (eoi) begin
      if (mode_r == M_STRING) begin
        em[0] = '{ctl_pkg::K_STRING, start_r, len_r, 1'b0}; n = 2'd1;
      end else if (mode_r == M_IDENT) begin
        em[0] = '{wkind, start_r, len_r, 1'b0}; n = 2'd1;
      end else if (mode_r == M_NUMBER) begin
        em[0] = '{ctl_pkg::K_NUMBER, start_r, len_r, 1'b0}; n = 2'd1;
      end else if (mode_r == M_OP) begin
        em[0] = '{ctl_pkg::single_kind(pend_r), start_r, 16'd1, 1'b0}; n = 2'd1;
      end
      em[n[0]] = '{ctl_pkg::K_EOF, pos_r, 16'd0, 1'b0};
      n = n + 2'd1;
      mode_nxt = M_IDLE; pend_nxt = '0; prev_nxt = '0; long_nxt = 1'b0;
      len_nxt = '0; start_nxt = '0; pos_nxt = '0;
    end else begin
      case (mode_r)
        M_LINE:  if (c == 8'h0A) mode_nxt = M_IDLE;
        M_BLOCK: if (c == "*") mode_nxt = M_STAR;
        M_STAR: begin
          if (c == "/") mode_nxt = M_IDLE;
          else if (c != "*") mode_nxt = M_BLOCK;
        end
        M_STRING: begin
          len_nxt = len_inc;
          if (c == "\"" && prev_r != "\\") begin
            em[0] = '{ctl_pkg::K_STRING, start_r, len_inc, 1'b0}; n = 2'd1;
            mode_nxt = M_IDLE;
          end
          prev_nxt = c;
        end
        M_IDENT: begin
          if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" ||
              (c >= "0" && c <= "9")) begin
            if (len_r < 16'(KEYWORD_MAX_LEN)) begin
              wr_en = 1'b1; wr_idx = len_r[IW-1:0];
            end else long_nxt = 1'b1;
            len_nxt = len_inc;
          end else begin
            em[0] = '{wkind, start_r, len_r, 1'b0}; n = 2'd1; do_start = 1'b1;
          end
        end
        M_NUMBER: begin
          if ((c >= "0" && c <= "9") || c == ".") len_nxt = len_inc;
          else begin
            em[0] = '{ctl_pkg::K_NUMBER, start_r, len_r, 1'b0}; n = 2'd1; do_start = 1'b1;
          end
        end
        M_OP: begin
          if (pend_r == "/" && c == "/") mode_nxt = M_LINE;
          else if (pend_r == "/" && c == "*") mode_nxt = M_BLOCK;
          else if (pk[7]) begin
            em[0] = '{pk[6:0], start_r, 16'd2, 1'b0}; n = 2'd1; mode_nxt = M_IDLE;
          end else begin
            em[0] = '{ctl_pkg::single_kind(pend_r), start_r, 16'd1, 1'b0}; n = 2'd1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
      // the byte opens fresh from idle, possibly after a token it ended
      if (do_start) begin
        mode_nxt = M_IDLE; start_nxt = pos_r; len_nxt = 16'd1;
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) len_nxt = 16'd0;
        else if (c == "\"") begin
          mode_nxt = M_STRING; prev_nxt = c;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
          mode_nxt = M_IDENT; wr_en = 1'b1; wr_idx = '0; long_nxt = 1'b0;
        end else if (c >= "0" && c <= "9") mode_nxt = M_NUMBER;
        else if (ctl_pkg::is_pair_start(c)) begin
          mode_nxt = M_OP; pend_nxt = c;
        end else begin
          em[n[0]] = '{ctl_pkg::single_kind(c), pos_r, 16'd1, 1'b0};
          n = n + 2'd1;
        end
      end
      pos_nxt = pos_r + 32'd1;
    end
    if (n == 2'd1) em[0].last = 1'b1;
    em[1].last = 1'b1;
  end

  assign push.cnt = acc ? n : 2'd0;
  assign push.t0 = em[0];
  assign push.t1 = em[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pend_r <= '0; prev_r <= '0; long_r <= 1'b0;
      len_r <= '0; start_r <= '0; pos_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt; pend_r <= pend_nxt; prev_r <= prev_nxt; long_r <= long_nxt;
      len_r <= len_nxt; start_r <= start_nxt; pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) wbuf_r[wr_idx] <= c;
  end

endmodule

// ===== sv/ctl_back.sv =====
`timescale 1ns / 1ps
// lexer back: token queue taking up to two words a cycle when it has room, drained into an output register
// depends on ctl_pkg, ctl_if
module ctl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ctl_pkg::push_t push,
  output logic           room_ok,
  ctl_out_if.source      out_if
);

  localparam int D = ctl_pkg::FIFO_DEPTH;
  localparam int AW = $clog2(D);

  ctl_pkg::tok_t q_r [D];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt, pop;
  ctl_pkg::tok_t ot_r;

  assign room_ok = cnt_r <= (AW + 1)'(D - 2);
  assign pop = cnt_r != '0 && (!ov_r || out_if.ready);
  assign ov_nxt = pop || (ov_r && !out_if.ready);
  assign wp_nxt = wp_r + AW'(push.cnt);
  assign rp_nxt = rp_r + AW'(pop);
  assign cnt_nxt = cnt_r + (AW + 1)'(push.cnt) - (AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wp_r] <= push.t0;
    if (push.cnt == 2'd2) q_r[wp_r + AW'(1)] <= push.t1;
    if (pop) ot_r <= q_r[rp_r];
  end

  assign out_if.valid = ov_r;
  assign out_if.token_kind = ot_r.kind;
  assign out_if.token_start = ot_r.start;
  assign out_if.token_length = ot_r.length;
  assign out_if.last = ot_r.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW + 1)'(D)) else $error("token queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> cnt_r <= (AW + 1)'(D - 2)) else $error("push without room");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_if.ready |=> ov_r && $stable(ot_r)) else $error("stalled token changed");
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.t0.last && push.t1.last) else $error("bad last marks");

endmodule
